>>> rtl/csf_pkg.sv
// ----------------------------------------------------------------------------
// csf_pkg: shared types and helpers for the case-insensitive substring finder
// Holds the configuration register set, register indexes and the ASCII
// case-folding function used by the front and back sections.
// ----------------------------------------------------------------------------
package csf_pkg;

    localparam int PATTERN_MAX_DEF   = 8;
    localparam int POSITION_BITS_DEF = 24;

    localparam int PATTERN_W  = 64;
    localparam int LENGTH_W   = 4;
    localparam int OFFSET_W   = 24;
    localparam int OUT_POS_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1,
        CFG_START_OFFSET   = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern_bytes;
        logic [LENGTH_W-1:0]  pattern_length;
        logic [OFFSET_W-1:0]  start_offset;
    } t_cfg;

    // Fold ASCII upper case letters to lower case; every other code is kept.
    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]}) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

>>> rtl/case_insensitive_substring_find_top.sv
// ----------------------------------------------------------------------------
// case_insensitive_substring_find_top: streaming case-insensitive search
// Finds the first occurrence of a pattern of up to eight characters in a
// byte stream, ignoring ASCII letter case.
// ----------------------------------------------------------------------------
// Usage: write the pattern, its length and the start offset through the
// configuration channel while no text is in flight. Then stream the text one
// byte per transaction on the slave side, with tlast on its final byte.
// For each text, exactly one result transaction leaves on the master side
// after the tlast byte: bit 0 of tdata says whether the pattern was found and
// bits 24:1 give the first position at or after the start offset (zero when
// nothing was found).
// Throughput is one byte per cycle while the queue has room. The tlast byte
// is written into the queue, then moves into the output register once that
// register is free, and tvalid is driven from the output register.
// When the receiver stalls, the result waits in the output register while
// the compare section keeps taking non-final bytes; only a second final byte
// waits, and once the two-entry queue fills, tready drops.
// Reset (synchronous, active low) clears the configuration to zero, empties
// the queue and drops any partial text or pending result.
// ----------------------------------------------------------------------------
module case_insensitive_substring_find_top #(
    parameter int PATTERN_MAX   = csf_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_BITS = csf_pkg::POSITION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Text input
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [7:0]                         i_s_axis_tdata,   // [7:0] text_byte
    input  logic                               i_s_axis_tlast,   // final_byte
    // Result output
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [csf_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,   // [0] match_found,
                                                                 // [24:1] match_position,
                                                                 // [31:25] zero
    // Configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [csf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [csf_pkg::PATTERN_W-1:0]      i_cfg_data
);
    import csf_pkg::*;

    localparam int ENTRY_W = 8 * PATTERN_MAX + POSITION_BITS + 1;

    t_cfg                 r_cfg;
    logic                 fifo_full;
    logic                 fifo_push;
    logic [ENTRY_W-1:0]   push_entry;
    logic                 fifo_valid;
    logic                 fifo_pop;
    logic [ENTRY_W-1:0]   pop_entry;
    logic                 found;
    logic [OUT_POS_W-1:0] position;

    // The configuration channel never stalls. Writes to an index outside
    // the register list complete and are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PATTERN_BYTES:  r_cfg.pattern_bytes  <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_cfg.pattern_length <= i_cfg_data[LENGTH_W-1:0];
                CFG_START_OFFSET:   r_cfg.start_offset   <= i_cfg_data[OFFSET_W-1:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    // Input section: window, position and folding.
    csf_front #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_full  (fifo_full),
        .o_push  (fifo_push),
        .o_entry (push_entry)
    );

    // Short queue so the input keeps flowing while a result is stalled.
    csf_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (push_entry),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_valid (fifo_valid),
        .o_data  (pop_entry)
    );

    // Compare section and result register.
    csf_back #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (fifo_valid),
        .i_entry     (pop_entry),
        .o_pop       (fifo_pop),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_found     (found),
        .o_position  (position)
    );

    assign o_m_axis_tdata = OUT_DATA_W'({position, found});

endmodule

>>> rtl/csf_fifo.sv
// ----------------------------------------------------------------------------
// csf_fifo: two-entry queue between the front and back sections
// Register-based; a push and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module csf_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == 2'(DEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == 2'd0))
        else $error("queue read while empty");

endmodule

>>> rtl/csf_front.sv
// ----------------------------------------------------------------------------
// csf_front: input section of the substring finder
// Accepts text bytes, folds them to lower case, keeps the recent window and
// the saturating position, and queues one entry per byte for the back end.
// ----------------------------------------------------------------------------
module csf_front #(
    parameter int PATTERN_MAX   = 8,
    parameter int POSITION_BITS = 24
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic [7:0]                                 i_byte,
    input  logic                                       i_last,
    input  logic                                       i_full,
    output logic                                       o_push,
    output logic [8*PATTERN_MAX+POSITION_BITS:0]       o_entry
);
    import csf_pkg::*;

    localparam int WIN_W = 8 * PATTERN_MAX;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [WIN_W-1:0]         r_win;
    logic [WIN_W-1:0]         n_win;
    logic [POSITION_BITS-1:0] r_pos;
    logic                     accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    // Newest byte sits in the lowest byte of the window.
    assign n_win   = (r_win << 8) | WIN_W'(fold_byte(i_byte));
    assign o_entry = {i_last, r_pos, n_win};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_pos <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_win <= '0;
                r_pos <= '0;
            end else begin
                r_win <= n_win;
                if (r_pos != POS_MAX) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_last && r_pos == POS_MAX |=> r_pos == POS_MAX)
        else $error("position counter wrapped");

endmodule

>>> rtl/csf_back.sv
// ----------------------------------------------------------------------------
// csf_back: compare section of the substring finder
// Compares each queued window with the folded pattern, remembers the first
// hit and holds the per-text result in an output register.
// ----------------------------------------------------------------------------
module csf_back #(
    parameter int PATTERN_MAX   = 8,
    parameter int POSITION_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  csf_pkg::t_cfg                        i_cfg,
    input  logic                                 i_valid,
    input  logic [8*PATTERN_MAX+POSITION_BITS:0] i_entry,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_found,
    output logic [csf_pkg::OUT_POS_W-1:0]        o_position
);
    import csf_pkg::*;

    localparam int WIN_W = 8 * PATTERN_MAX;
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PW1   = POSITION_BITS + 1;
    localparam int CW    = (PW1 > OFFSET_W) ? PW1 : OFFSET_W;
    localparam int XW    = (POSITION_BITS > OUT_POS_W) ? POSITION_BITS : OUT_POS_W;

    logic [WIN_W-1:0]         win;
    logic [POSITION_BITS-1:0] pos;
    logic                     last;
    logic [7:0]               win_byte [PATTERN_MAX];
    logic [LEN_W-1:0]         len;
    logic [PW1-1:0]           pos_p1;
    logic [PW1-1:0]           begin_pos;
    logic                     fits;
    logic                     begin_ok;
    logic                     same;
    logic                     match_now;
    logic [POSITION_BITS-1:0] hit_pos;
    logic [XW-1:0]            hit_pos_x;
    logic                     out_free;

    logic                     r_hit;
    logic [POSITION_BITS-1:0] r_first;
    logic                     r_out_valid;
    logic                     r_found;
    logic [OUT_POS_W-1:0]     r_position;

    assign {last, pos, win} = i_entry;

    always_comb begin
        for (int b = 0; b < PATTERN_MAX; b++) begin
            win_byte[b] = win[8*b +: 8];
        end
    end

    assign len = (i_cfg.pattern_length > LENGTH_W'(PATTERN_MAX))
               ? LEN_W'(PATTERN_MAX) : LEN_W'(i_cfg.pattern_length);

    assign pos_p1    = PW1'(pos) + PW1'(1);
    assign fits      = pos_p1 >= PW1'(len);
    assign begin_pos = (len == '0) ? PW1'(pos) : pos_p1 - PW1'(len);
    assign begin_ok  = CW'(begin_pos) >= CW'(i_cfg.start_offset);

    // Pattern character i lines up with window byte len-1-i.
    always_comb begin
        logic [LEN_W-1:0] sel;
        same = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            sel = len - LEN_W'(1) - LEN_W'(i);
            if (LEN_W'(i) < len) begin
                if (fold_byte(i_cfg.pattern_bytes[8*i +: 8]) != win_byte[IDX_W'(sel)]) begin
                    same = 1'b0;
                end
            end
        end
    end

    assign match_now = !r_hit && fits && begin_ok && same;
    assign hit_pos   = r_hit ? r_first : begin_pos[POSITION_BITS-1:0];
    assign hit_pos_x = XW'(hit_pos);

    assign out_free = !r_out_valid || i_out_ready;
    assign o_pop    = i_valid && (!last || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit       <= 1'b0;
            r_first     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && last) begin
                r_hit       <= 1'b0;
                r_first     <= '0;
                r_out_valid <= 1'b1;
            end else begin
                if (o_pop && match_now) begin
                    r_hit   <= 1'b1;
                    r_first <= begin_pos[POSITION_BITS-1:0];
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && last) begin
            r_found    <= r_hit || match_now;
            r_position <= (r_hit || match_now) ? hit_pos_x[OUT_POS_W-1:0] : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_position;

    a_hit_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && last |=> !r_hit)
        else $error("hit flag survived end of text");

    a_no_hit_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_found |-> r_position == '0)
        else $error("position reported without a match");

endmodule
